// ----- hw/rtl/cawf_pkg.sv -----
// Shared types and operation codes for the flag-keeping 8-bit CPU ALU.
package cawf_pkg;

    localparam int FUNC_W = 5;
    localparam int DATA_W = 16;
    localparam int BYTE_W = 8;

    typedef logic [FUNC_W-1:0] func_t;
    typedef logic [DATA_W-1:0] word_t;
    typedef logic [BYTE_W-1:0] byte_t;

    // Flag nibble, bit 3 down to bit 0: Z N H C.
    typedef struct packed {
        logic z;
        logic n;
        logic h;
        logic c;
    } flags_t;

    localparam func_t FUNC_ADD   = 5'd0;
    localparam func_t FUNC_ADC   = 5'd1;
    localparam func_t FUNC_SUB   = 5'd2;
    localparam func_t FUNC_SBC   = 5'd3;
    localparam func_t FUNC_INC   = 5'd4;
    localparam func_t FUNC_DEC   = 5'd5;
    localparam func_t FUNC_AND   = 5'd6;
    localparam func_t FUNC_OR    = 5'd7;
    localparam func_t FUNC_XOR   = 5'd8;
    localparam func_t FUNC_ADD16 = 5'd9;
    localparam func_t FUNC_ADDSP = 5'd10;
    localparam func_t FUNC_RLC   = 5'd11;
    localparam func_t FUNC_RL    = 5'd12;
    localparam func_t FUNC_RRC   = 5'd13;
    localparam func_t FUNC_RR    = 5'd14;
    localparam func_t FUNC_SLA   = 5'd15;
    localparam func_t FUNC_SWAP  = 5'd16;
    localparam func_t FUNC_SRA   = 5'd17;
    localparam func_t FUNC_SRL   = 5'd18;

    localparam flags_t FLAGS_RESET = '{z: 1'b0, n: 1'b0, h: 1'b0, c: 1'b0};

endpackage

// ----- hw/rtl/cawf_alu.sv -----
// Combinational datapath: computes the result and new flags of one operation.
module cawf_alu (
    input  cawf_pkg::func_t  func,
    input  cawf_pkg::word_t  operand_a,
    input  cawf_pkg::word_t  operand_b,
    input  cawf_pkg::flags_t flags_in,
    output cawf_pkg::word_t  result,
    output cawf_pkg::flags_t flags_out
);
    import cawf_pkg::*;

    byte_t      a;
    byte_t      b;
    logic       cin;
    logic       t;
    logic [8:0] sum9;
    logic [4:0] sum5;
    logic [16:0] sum17;
    logic [12:0] sum13;
    byte_t      r8;
    word_t      sext_b;

    assign a      = operand_a[BYTE_W-1:0];
    assign b      = operand_b[BYTE_W-1:0];
    assign cin    = flags_in.c;
    assign sext_b = {{(DATA_W-BYTE_W){b[BYTE_W-1]}}, b};

    always_comb
    begin
        t         = 1'b0;
        sum9      = '0;
        sum5      = '0;
        sum17     = '0;
        sum13     = '0;
        r8        = '0;
        result    = '0;
        flags_out = flags_in;
        case (func)
            FUNC_ADD, FUNC_ADC:
            begin
                t    = (func == FUNC_ADC) ? cin : 1'b0;
                sum9 = {1'b0, a} + {1'b0, b} + {8'd0, t};
                sum5 = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, t};
                r8   = sum9[7:0];
                flags_out = '{z: (r8 == '0), n: 1'b0, h: sum5[4], c: sum9[8]};
            end
            FUNC_SUB, FUNC_SBC:
            begin
                t    = (func == FUNC_SBC) ? cin : 1'b0;
                sum9 = {1'b0, a} - {1'b0, b} - {8'd0, t};
                sum5 = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, t};
                r8   = sum9[7:0];
                flags_out = '{z: (r8 == '0), n: 1'b1, h: sum5[4], c: sum9[8]};
            end
            FUNC_INC:
            begin
                r8 = a + 8'd1;
                flags_out = '{z: (r8 == '0), n: 1'b0, h: (a[3:0] == 4'hF), c: cin};
            end
            FUNC_DEC:
            begin
                r8 = a - 8'd1;
                flags_out = '{z: (r8 == '0), n: 1'b1, h: (a[3:0] == 4'h0), c: cin};
            end
            FUNC_AND:
            begin
                r8 = a & b;
                flags_out = '{z: (r8 == '0), n: 1'b0, h: 1'b1, c: 1'b0};
            end
            FUNC_OR:
            begin
                r8 = a | b;
                flags_out = '{z: (r8 == '0), n: 1'b0, h: 1'b0, c: 1'b0};
            end
            FUNC_XOR:
            begin
                r8 = a ^ b;
                flags_out = '{z: (r8 == '0), n: 1'b0, h: 1'b0, c: 1'b0};
            end
            FUNC_RLC, FUNC_RL, FUNC_SLA:
            begin
                t = a[7];
                if (func == FUNC_RLC)
                begin
                    r8 = {a[6:0], a[7]};
                end
                else if (func == FUNC_RL)
                begin
                    r8 = {a[6:0], cin};
                end
                else
                begin
                    r8 = {a[6:0], 1'b0};
                end
                flags_out = '{z: (r8 == '0), n: 1'b0, h: 1'b0, c: t};
            end
            FUNC_RRC, FUNC_RR, FUNC_SRA, FUNC_SRL:
            begin
                t = a[0];
                if (func == FUNC_RRC)
                begin
                    r8 = {a[0], a[7:1]};
                end
                else if (func == FUNC_RR)
                begin
                    r8 = {cin, a[7:1]};
                end
                else if (func == FUNC_SRA)
                begin
                    r8 = {a[7], a[7:1]};
                end
                else
                begin
                    r8 = {1'b0, a[7:1]};
                end
                flags_out = '{z: (r8 == '0), n: 1'b0, h: 1'b0, c: t};
            end
            FUNC_SWAP:
            begin
                r8 = {a[3:0], a[7:4]};
                flags_out = '{z: (r8 == '0), n: 1'b0, h: 1'b0, c: 1'b0};
            end
            default:
            begin
                r8 = '0;
            end
        endcase

        result = {{(DATA_W-BYTE_W){1'b0}}, r8};

        if (func == FUNC_ADD16)
        begin
            sum17  = {1'b0, operand_a} + {1'b0, operand_b};
            sum13  = {1'b0, operand_a[11:0]} + {1'b0, operand_b[11:0]};
            result = sum17[DATA_W-1:0];
            flags_out = '{z: flags_in.z, n: 1'b0, h: sum13[12], c: sum17[16]};
        end
        else if (func == FUNC_ADDSP)
        begin
            sum9   = {1'b0, a} + {1'b0, b};
            sum5   = {1'b0, a[3:0]} + {1'b0, b[3:0]};
            result = operand_a + sext_b;
            flags_out = '{z: 1'b0, n: 1'b0, h: sum5[4], c: sum9[8]};
        end
    end

endmodule

// ----- hw/rtl/cpu_alu_with_flags_top.sv -----
// Top level of the flag-keeping 8-bit CPU ALU: input register, datapath, result register.
//
// This block executes one ALU operation per item and returns the 16-bit result
// (8-bit results zero-extended) together with the new Z N H C flag nibble. The
// flag register lives inside the block: each item sees the flags left by the
// item before it, and operations that do not touch a flag keep it (INC and DEC
// keep C, 16-bit ADD keeps Z, an unknown operation code returns zero and keeps
// all flags). Both channels use valid/ready. An item is captured in an input
// register, passes through the combinational datapath, and lands in a result
// register once that register is empty or its item is being taken; the result
// is then held on the output until it is taken.
// The block takes one item per cycle while the output side keeps up; the
// carry dependency between consecutive items is covered because the flag
// register is written in the same cycle an item moves into the result register.
// The flags reset to all zero.
module cpu_alu_with_flags_top (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  cawf_pkg::func_t  func,
    input  cawf_pkg::word_t  operand_a,
    input  cawf_pkg::word_t  operand_b,
    output logic             out_valid,
    input  logic             out_ready,
    output cawf_pkg::word_t  result,
    output logic [3:0]       flags_out
);
    import cawf_pkg::*;

    // Input register stage.
    logic   in_valid_reg;
    func_t  func_reg;
    word_t  a_reg;
    word_t  b_reg;

    // Result register stage and the architectural flag register.
    logic   out_valid_reg;
    word_t  result_reg;
    flags_t flags_out_reg;
    flags_t flag_reg;

    // Datapath outputs.
    word_t  alu_result;
    flags_t alu_flags;

    // The item in the input register moves on whenever the result register
    // is empty or its item is being taken this cycle.
    logic   advance;

    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign result    = result_reg;
    assign flags_out = flags_out_reg;

    cawf_alu u_alu (
        .func      (func_reg),
        .operand_a (a_reg),
        .operand_b (b_reg),
        .flags_in  (flag_reg),
        .result    (alu_result),
        .flags_out (alu_flags)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            flag_reg      <= FLAGS_RESET;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                flag_reg      <= alu_flags;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            func_reg <= func;
            a_reg    <= operand_a;
            b_reg    <= operand_b;
        end
        if (advance)
        begin
            result_reg    <= alu_result;
            flags_out_reg <= alu_flags;
        end
    end

endmodule
